// ----- hdl/rgbcc_pkg.sv -----
`default_nettype none
package rgbcc_pkg;

   // Field widths
   localparam int CHAN_W     = 16;
   localparam int HUE_W      = 9;
   localparam int SAT_W      = 7;
   localparam int CLASS_W    = 3;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   // Datapath widths
   localparam int XY_W    = 32;
   localparam int Z_W     = 28;
   localparam int REM_W   = 24;
   localparam int DEN_W   = CHAN_W + 1;
   localparam int STEPS   = 20;
   localparam int QBITS   = SAT_W;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_VARIANT  = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_OFF_RED  = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_OFF_GRN  = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_OFF_BLU  = 8'd3;

   // Color classes
   localparam logic [CLASS_W-1:0] CLASS_BLACK  = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_WHITE  = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_RED    = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_YELLOW = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_GREEN  = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_BLUE   = 3'd5;

   // Angles in radians scaled by 2^24
   localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [Z_W-1:0] ATAN_Q24 [STEPS] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
      28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32
   };

   // Word that travels down the row of cells
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   grey;
      logic [REM_W-1:0]       rem;
      logic [DEN_W-1:0]       den;
      logic [QBITS-1:0]       quo;
      logic [CHAN_W-1:0]      inten;
      logic [CHAN_W-1:0]      r;
      logic [CHAN_W-1:0]      g;
      logic [CHAN_W-1:0]      b;
   } cell_type;

   // Color decision with the variant's thresholds and hue bands.
   function automatic logic [CLASS_W-1:0] classify(input logic var_sel,
                                                   input logic signed [HUE_W-1:0] h,
                                                   input logic [SAT_W-1:0] sat,
                                                   input logic [CHAN_W-1:0] inten);
      logic [CLASS_W-1:0] c;
      if (!var_sel) begin
         if (inten < 16'd8) c = CLASS_BLACK;
         else if (sat < 7'd35 && inten > 16'd30) c = CLASS_WHITE;
         else if (h > -9'sd20 && h <= 9'sd15) c = CLASS_RED;
         else if (h > 9'sd15 && h <= 9'sd60) c = CLASS_YELLOW;
         else if (h > 9'sd60 && h <= 9'sd175) c = CLASS_GREEN;
         else c = CLASS_BLUE;
      end else begin
         if (inten < 16'd400) c = CLASS_BLACK;
         else if (sat < 7'd20 && inten > 16'd500) c = CLASS_WHITE;
         else if (h > -9'sd100 && h <= 9'sd10) c = CLASS_RED;
         else if (h > 9'sd10 && h <= 9'sd90) c = CLASS_YELLOW;
         else if (h > -9'sd150 && h <= -9'sd100) c = CLASS_BLUE;
         else c = CLASS_GREEN;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/rgbcc_ifs.sv -----
`default_nettype none
interface rgbcc_req_if;
   logic                               valid;
   logic                               ready;
   logic [rgbcc_pkg::CHAN_W-1:0]       raw_red;
   logic [rgbcc_pkg::CHAN_W-1:0]       raw_green;
   logic [rgbcc_pkg::CHAN_W-1:0]       raw_blue;
   modport source(output valid, raw_red, raw_green, raw_blue, input ready);
   modport sink(input valid, raw_red, raw_green, raw_blue, output ready);
endinterface

interface rgbcc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rgbcc_pkg::CLASS_W-1:0]      color_class;
   logic signed [rgbcc_pkg::HUE_W-1:0] hue_degrees;
   logic [rgbcc_pkg::SAT_W-1:0]        saturation_pct;
   logic [rgbcc_pkg::CHAN_W-1:0]       intensity;
   logic [rgbcc_pkg::CHAN_W-1:0]       balanced_red;
   logic [rgbcc_pkg::CHAN_W-1:0]       balanced_green;
   logic [rgbcc_pkg::CHAN_W-1:0]       balanced_blue;
   modport source(output valid, color_class, hue_degrees, saturation_pct, intensity,
                  balanced_red, balanced_green, balanced_blue, input ready);
   modport sink(input valid, color_class, hue_degrees, saturation_pct, intensity,
                balanced_red, balanced_green, balanced_blue, output ready);
endinterface

interface rgbcc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rgbcc_pkg::CSR_ADDR_W-1:0]   addr;
   logic [rgbcc_pkg::CSR_DATA_W-1:0]   data;
   modport source(output valid, addr, data, input ready);
   modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/rgbcc_front.sv -----
`default_nettype none
module rgbcc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [rgbcc_pkg::CHAN_W-1:0]  raw_red,
   input  wire logic [rgbcc_pkg::CHAN_W-1:0]  raw_green,
   input  wire logic [rgbcc_pkg::CHAN_W-1:0]  raw_blue,
   input  wire logic                          variant,
   input  wire logic [rgbcc_pkg::CHAN_W-1:0]  off_red,
   input  wire logic [rgbcc_pkg::CHAN_W-1:0]  off_green,
   input  wire logic [rgbcc_pkg::CHAN_W-1:0]  off_blue,
   output rgbcc_pkg::cell_type                out_word,
   output logic                               out_valid
);
   localparam int W = rgbcc_pkg::CHAN_W;

   logic [2:0] vld_ff, vld_in;

   // Stage 1: white balance and dark offset
   logic [W-1:0] r1_ff, g1_ff, b1_ff, r1_in, g1_in, b1_in;

   function automatic logic [W-1:0] balance(input logic [W-1:0] raw,
                                            input logic [2:0] gain,
                                            input logic [W-1:0] off);
      logic [W+2:0] prod;
      logic [W-1:0] p;
      prod = (W+3)'(raw) * (W+3)'(gain);
      p    = prod[W-1:0];
      return (p > off) ? p - off : W'(1);
   endfunction

   always_comb begin
      r1_in = balance(raw_red,   variant ? 3'd2 : 3'd5, off_red);
      g1_in = balance(raw_green, variant ? 3'd3 : 3'd4, off_green);
      b1_in = balance(raw_blue,  variant ? 3'd4 : 3'd3, off_blue);
   end

   // Stage 2: extremes, differences and channel sum
   logic [W-1:0]        r2_ff, g2_ff, b2_ff, mx2_ff, df2_ff, mx2_in, mn2_in, df2_in;
   logic signed [W+2:0] dx2_ff, dx2_in;
   logic signed [W:0]   dy2_ff, dy2_in;
   logic [W+1:0]        sm2_ff, sm2_in;

   always_comb begin
      mx2_in = r1_ff;
      mn2_in = r1_ff;
      if (g1_ff > mx2_in) mx2_in = g1_ff;
      if (b1_ff > mx2_in) mx2_in = b1_ff;
      if (g1_ff < mn2_in) mn2_in = g1_ff;
      if (b1_ff < mn2_in) mn2_in = b1_ff;
      df2_in = mx2_in - mn2_in;
      dx2_in = signed'(((W+3)'(r1_ff) << 1) - (W+3)'(g1_ff) - (W+3)'(b1_ff));
      dy2_in = signed'((W+1)'(g1_ff) - (W+1)'(b1_ff));
      sm2_in = (W+2)'(r1_ff) + (W+2)'(g1_ff) + (W+2)'(b1_ff);
   end

   // Stage 3: scaled vector, divider operands, intensity by reciprocal
   logic signed [rgbcc_pkg::XY_W-1:0] x3_ff, y3_ff, x3_in, y3_in;
   logic [rgbcc_pkg::REM_W-1:0]       n3_ff, n3_in;
   logic [rgbcc_pkg::DEN_W-1:0]       d3_ff, d3_in;
   logic [W-1:0]                      r3_ff, g3_ff, b3_ff, i3_ff, i3_in;
   logic                              gr3_ff, gr3_in;
   logic [36:0]                       iprod;

   always_comb begin
      x3_in  = rgbcc_pkg::XY_W'(dx2_ff) * 32'sd1000;
      y3_in  = rgbcc_pkg::XY_W'(dy2_ff) * 32'sd1732;
      n3_in  = rgbcc_pkg::REM_W'(df2_ff) * 24'd200 + rgbcc_pkg::REM_W'(mx2_ff);
      d3_in  = {mx2_ff, 1'b0};
      iprod  = 37'(sm2_ff) * 37'd174763;
      i3_in  = iprod[34:19];
      gr3_in = (dx2_ff == '0) && (dy2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         r1_ff  <= r1_in;  g1_ff <= g1_in;  b1_ff <= b1_in;
         r2_ff  <= r1_ff;  g2_ff <= g1_ff;  b2_ff <= b1_ff;
         mx2_ff <= mx2_in; df2_ff <= df2_in;
         dx2_ff <= dx2_in; dy2_ff <= dy2_in; sm2_ff <= sm2_in;
         x3_ff  <= x3_in;  y3_ff <= y3_in;  n3_ff <= n3_in; d3_ff <= d3_in;
         i3_ff  <= i3_in;  gr3_ff <= gr3_in;
         r3_ff  <= r2_ff;  g3_ff <= g2_ff;  b3_ff <= b2_ff;
      end
   end

   assign vld_in = {vld_ff[1:0], in_valid};

   // Quarter-turn pre-rotation into the right half plane
   always_comb begin
      out_word.x = x3_ff;
      out_word.y = y3_ff;
      out_word.z = '0;
      if (x3_ff < 0) begin
         if (y3_ff >= 0) begin
            out_word.x = y3_ff;
            out_word.y = -x3_ff;
            out_word.z = rgbcc_pkg::HALF_PI_Q24;
         end else begin
            out_word.x = -y3_ff;
            out_word.y = x3_ff;
            out_word.z = -rgbcc_pkg::HALF_PI_Q24;
         end
      end
      out_word.grey  = gr3_ff;
      out_word.rem   = n3_ff;
      out_word.den   = d3_ff;
      out_word.quo   = '0;
      out_word.inten = i3_ff;
      out_word.r     = r3_ff;
      out_word.g     = g3_ff;
      out_word.b     = b3_ff;
   end

   assign out_valid = vld_ff[2];
endmodule
`default_nettype wire

// ----- hdl/rgbcc_cell.sv -----
`default_nettype none
module rgbcc_cell #(
   parameter int STEP = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  rgbcc_pkg::cell_type       in_word,
   output rgbcc_pkg::cell_type       out_word,
   output logic                      out_valid
);
   // Quotient bit formed here; cells past the quotient width leave it alone.
   localparam int QIDX = (STEP < rgbcc_pkg::QBITS) ? (rgbcc_pkg::QBITS - 1 - STEP) : 0;

   rgbcc_pkg::cell_type word_ff, word_in;
   logic                valid_ff;

   // One vectoring rotation, plus one quotient bit in the leading cells
   always_comb begin
      logic signed [rgbcc_pkg::XY_W-1:0] xs, ys;
      logic [rgbcc_pkg::REM_W-1:0]       sub;
      xs      = in_word.x >>> STEP;
      ys      = in_word.y >>> STEP;
      word_in = in_word;
      if (in_word.y >= 0) begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + rgbcc_pkg::ATAN_Q24[STEP];
      end else begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - rgbcc_pkg::ATAN_Q24[STEP];
      end
      sub = '0;
      if (STEP < rgbcc_pkg::QBITS) begin
         sub = rgbcc_pkg::REM_W'(in_word.den) << QIDX;
         if (in_word.rem >= sub) begin
            word_in.rem = in_word.rem - sub;
            word_in.quo[QIDX] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_word  = word_ff;
   assign out_valid = valid_ff;
endmodule
`default_nettype wire

// ----- hdl/rgbcc_back.sv -----
`default_nettype none
module rgbcc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              variant,
   input  wire logic                              in_valid,
   input  rgbcc_pkg::cell_type                    in_word,
   output logic                                   out_valid,
   output logic [rgbcc_pkg::CLASS_W-1:0]          color_class,
   output logic signed [rgbcc_pkg::HUE_W-1:0]     hue_degrees,
   output logic [rgbcc_pkg::SAT_W-1:0]            saturation_pct,
   output logic [rgbcc_pkg::CHAN_W-1:0]           intensity,
   output logic [rgbcc_pkg::CHAN_W-1:0]           balanced_red,
   output logic [rgbcc_pkg::CHAN_W-1:0]           balanced_green,
   output logic [rgbcc_pkg::CHAN_W-1:0]           balanced_blue
);
   localparam int W = rgbcc_pkg::CHAN_W;

   logic [2:0] vld_ff, vld_in;

   // Stage 1: angle times 573
   logic signed [38:0] num_ff, num_in;
   rgbcc_pkg::cell_type w1_ff;
   assign num_in = 39'(in_word.z) * 39'sd573;

   // Stage 2: magnitude rounded and divided by 2^24
   logic [37:0] mag;
   logic [11:0] wq_ff, wq_in;
   logic        neg_ff;
   rgbcc_pkg::cell_type w2_ff;
   always_comb begin
      mag   = num_ff[38] ? 38'(-num_ff) : 38'(num_ff);
      mag   = mag + 38'd83886080;
      wq_in = mag[35:24];
   end

   // Stage 3: divide by ten, sign, clamp and classify
   logic [27:0]                         qprod;
   logic [8:0]                          qmag;
   logic signed [rgbcc_pkg::HUE_W-1:0]  hue_in;
   logic [rgbcc_pkg::CLASS_W-1:0]       cls_in;
   always_comb begin
      qprod = 28'(wq_ff) * 28'd6554;
      qmag  = (qprod[27:16] > 12'd180) ? 9'd180 : qprod[24:16];
      if (w2_ff.grey) hue_in = '0;
      else if (neg_ff) hue_in = -signed'(qmag);
      else hue_in = signed'(qmag);
      cls_in = rgbcc_pkg::classify(variant, hue_in, w2_ff.quo, w2_ff.inten);
   end

   assign vld_in = {vld_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         num_ff         <= num_in;
         w1_ff          <= in_word;
         wq_ff          <= wq_in;
         neg_ff         <= num_ff[38];
         w2_ff          <= w1_ff;
         color_class    <= cls_in;
         hue_degrees    <= hue_in;
         saturation_pct <= w2_ff.quo;
         intensity      <= w2_ff.inten;
         balanced_red   <= w2_ff.r;
         balanced_green <= w2_ff.g;
         balanced_blue  <= w2_ff.b;
      end
   end

   assign out_valid = vld_ff[2];
endmodule
`default_nettype wire

// ----- hdl/rgb_color_classifier.sv -----
// Throughput: one word per cycle while no result word waits at the output;
// three front stages, a row of 20 rotation cells (the first 7 also form
// the saturation quotient) and three back stages.
// The whole pipeline holds while a result word waits at the output.
// Reset clears all valid bits and sets every configuration register to zero.
`default_nettype none
module rgb_color_classifier (
   input  wire logic      clock,
   input  wire logic      reset,
   rgbcc_req_if.sink      req_bus,
   rgbcc_rsp_if.source    rsp_bus,
   rgbcc_csr_if.sink      csr_bus
);
   localparam int W = rgbcc_pkg::CHAN_W;
   localparam int N = rgbcc_pkg::STEPS;

   logic         variant_ff;
   logic [W-1:0] off_red_ff, off_green_ff, off_blue_ff;
   logic         en;

   // Configuration registers
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= 1'b0;
         off_red_ff   <= '0;
         off_green_ff <= '0;
         off_blue_ff  <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            rgbcc_pkg::REG_VARIANT: variant_ff   <= csr_bus.data[0];
            rgbcc_pkg::REG_OFF_RED: off_red_ff   <= csr_bus.data[W-1:0];
            rgbcc_pkg::REG_OFF_GRN: off_green_ff <= csr_bus.data[W-1:0];
            rgbcc_pkg::REG_OFF_BLU: off_blue_ff  <= csr_bus.data[W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline advances unless a result word is stalled
   assign en            = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = en;

   rgbcc_pkg::cell_type chain [N+1];
   logic                chain_vld [N+1];

   rgbcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .raw_red   (req_bus.raw_red),
      .raw_green (req_bus.raw_green),
      .raw_blue  (req_bus.raw_blue),
      .variant   (variant_ff),
      .off_red   (off_red_ff),
      .off_green (off_green_ff),
      .off_blue  (off_blue_ff),
      .out_word  (chain[0]),
      .out_valid (chain_vld[0])
   );

   // Row of rotation cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      rgbcc_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_vld[i]),
         .in_word   (chain[i]),
         .out_word  (chain[i+1]),
         .out_valid (chain_vld[i+1])
      );
   end

   rgbcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .variant        (variant_ff),
      .in_valid       (chain_vld[N]),
      .in_word        (chain[N]),
      .out_valid      (rsp_bus.valid),
      .color_class    (rsp_bus.color_class),
      .hue_degrees    (rsp_bus.hue_degrees),
      .saturation_pct (rsp_bus.saturation_pct),
      .intensity      (rsp_bus.intensity),
      .balanced_red   (rsp_bus.balanced_red),
      .balanced_green (rsp_bus.balanced_green),
      .balanced_blue  (rsp_bus.balanced_blue)
   );
endmodule
`default_nettype wire

// ----- hdl/rgbcc_checker.sv -----
`default_nettype none
module rgbcc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [2:0]        color_class,
   input wire logic signed [8:0] hue_degrees,
   input wire logic [6:0]        saturation_pct,
   input wire logic [15:0]       balanced_red,
   input wire logic [15:0]       balanced_green,
   input wire logic [15:0]       balanced_blue
);
   // A stalled result word stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Balanced channels are floored at one.
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (balanced_red != 0 && balanced_green != 0 && balanced_blue != 0))
      else $error("balanced channel is zero");

   // Saturation never exceeds one hundred percent.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> saturation_pct <= 7'd100)
      else $error("saturation out of range");

   // Hue stays within a half turn either way.
   a_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (hue_degrees >= -9'sd180 && hue_degrees <= 9'sd180))
      else $error("hue out of range");

   // Class code names one of the six colors.
   a_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> color_class <= 3'd5)
      else $error("color class out of range");
endmodule

bind rgb_color_classifier rgbcc_checker u_rgbcc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .color_class    (rsp_bus.color_class),
   .hue_degrees    (rsp_bus.hue_degrees),
   .saturation_pct (rsp_bus.saturation_pct),
   .balanced_red   (rsp_bus.balanced_red),
   .balanced_green (rsp_bus.balanced_green),
   .balanced_blue  (rsp_bus.balanced_blue)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int  RUN_LIMIT = 200000;
   localparam int  DRAIN_CYCLES = 40;
   localparam int  RANDOM_PER_PHASE = 100;
   localparam logic [rgbcc_pkg::CSR_ADDR_W-1:0] REG_UNUSED = 8'd200;
   localparam longint HALF_PI = 64'sd26353589;
   localparam longint DEG_SCALE = 64'sd167772160;

   typedef logic [rgbcc_pkg::CHAN_W-1:0]     chan_type;
   typedef logic [rgbcc_pkg::CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [rgbcc_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      logic [rgbcc_pkg::CLASS_W-1:0]      color_class;
      logic signed [rgbcc_pkg::HUE_W-1:0] hue;
      logic [rgbcc_pkg::SAT_W-1:0]        sat;
      chan_type                           inten;
      chan_type                           r;
      chan_type                           g;
      chan_type                           b;
   } hsi_type;

   typedef struct {
      chan_type r;
      chan_type g;
      chan_type b;
      bit       known;
      hsi_type  want;
   } stim_row_type;

   logic clock;
   logic reset;
   rgbcc_req_if req_bus();
   rgbcc_rsp_if rsp_bus();
   rgbcc_csr_if csr_bus();

   rgb_color_classifier i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Configuration as the block should hold it.
   logic     cfg_variant;
   chan_type cfg_off_red, cfg_off_grn, cfg_off_blu;

   hsi_type pending_hsi[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   bit      calm;
   longint  atan_steps[rgbcc_pkg::STEPS] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
   };

   // Clock.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("** rgb_color_classifier: FAILED **");
         $finish;
      end
   end

   // Gain, wrap to the channel width, subtract the dark offset, floor at 1.
   function automatic chan_type white_balance(chan_type raw, int gain, chan_type off);
      longint p;
      longint d;
      p = (longint'(raw) * gain) & 64'hFFFF;
      d = p - longint'(off);
      if (d < 1) d = 1;
      return chan_type'(d);
   endfunction

   // Vectoring CORDIC on exact integers, result in whole degrees.
   function automatic int hue_angle(longint r, longint g, longint b);
      longint x, y, z, t, xs, ys, num, mag, q;
      x = 1000 * (2 * r - g - b);
      y = 1732 * (g - b);
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < rgbcc_pkg::STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_steps[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_steps[i];
         end
      end
      num = 573 * z;
      mag = (num < 0) ? -num : num;
      q = (mag + DEG_SCALE / 2) / DEG_SCALE;
      if (num < 0) q = -q;
      if (q > 180) q = 180;
      if (q < -180) q = -180;
      return int'(q);
   endfunction

   // Color decision from the variant's thresholds and hue bands.
   function automatic logic [rgbcc_pkg::CLASS_W-1:0] color_of(logic v, int h, int sat,
                                                              int inten);
      if (!v) begin
         if (inten < 8) return rgbcc_pkg::CLASS_BLACK;
         if (sat < 35 && inten > 30) return rgbcc_pkg::CLASS_WHITE;
         if (h > -20 && h <= 15) return rgbcc_pkg::CLASS_RED;
         if (h > 15 && h <= 60) return rgbcc_pkg::CLASS_YELLOW;
         if (h > 60 && h <= 175) return rgbcc_pkg::CLASS_GREEN;
         return rgbcc_pkg::CLASS_BLUE;
      end
      if (inten < 400) return rgbcc_pkg::CLASS_BLACK;
      if (sat < 20 && inten > 500) return rgbcc_pkg::CLASS_WHITE;
      if (h > -100 && h <= 10) return rgbcc_pkg::CLASS_RED;
      if (h > 10 && h <= 90) return rgbcc_pkg::CLASS_YELLOW;
      if (h > -150 && h <= -100) return rgbcc_pkg::CLASS_BLUE;
      return rgbcc_pkg::CLASS_GREEN;
   endfunction

   // Full expected result word for one raw sample.
   function automatic hsi_type predict_hsi(chan_type raw_r, chan_type raw_g, chan_type raw_b);
      hsi_type res;
      longint  r, g, b, mx, mn, sat, inten;
      int      h;
      r = longint'(white_balance(raw_r, cfg_variant ? 2 : 5, cfg_off_red));
      g = longint'(white_balance(raw_g, cfg_variant ? 3 : 4, cfg_off_grn));
      b = longint'(white_balance(raw_b, cfg_variant ? 4 : 3, cfg_off_blu));
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sat = (200 * (mx - mn) + mx) / (2 * mx);
      inten = (r + g + b) / 3;
      h = hue_angle(r, g, b);
      res.color_class = color_of(cfg_variant, h, int'(sat), int'(inten));
      res.hue = rgbcc_pkg::HUE_W'(h);
      res.sat = rgbcc_pkg::SAT_W'(sat);
      res.inten = chan_type'(inten);
      res.r = chan_type'(r);
      res.g = chan_type'(g);
      res.b = chan_type'(b);
      return res;
   endfunction

   // Register write; the model copy follows on acceptance.
   task automatic csr_write(csr_addr_type idx, csr_data_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         rgbcc_pkg::REG_VARIANT: cfg_variant = value[0];
         rgbcc_pkg::REG_OFF_RED: cfg_off_red = value;
         rgbcc_pkg::REG_OFF_GRN: cfg_off_grn = value;
         rgbcc_pkg::REG_OFF_BLU: cfg_off_blu = value;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // Send one sample word and queue the expected result, or a typed-in one.
   task automatic send_sample(chan_type r, chan_type g, chan_type b, bit known,
                              hsi_type want);
      int gap;
      gap = calm ? 0 : int'($urandom_range(0, 4));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.raw_red <= r;
      req_bus.raw_green <= g;
      req_bus.raw_blue <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_hsi.push_back(known ? want : predict_hsi(r, g, b));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_hsi.size() != 0) @(posedge clock);
   endtask

   // Random sample: full range, low counts near the thresholds, or near grey.
   task automatic send_random();
      int       mode;
      chan_type base;
      hsi_type  none;
      none = '0;
      mode = int'($urandom_range(0, 9));
      if (mode < 4) begin
         send_sample(chan_type'($urandom), chan_type'($urandom), chan_type'($urandom),
                     1'b0, none);
      end else if (mode < 8) begin
         send_sample(chan_type'($urandom_range(0, 400)), chan_type'($urandom_range(0, 400)),
                     chan_type'($urandom_range(0, 400)), 1'b0, none);
      end else begin
         base = chan_type'($urandom_range(0, 3000));
         send_sample(base + chan_type'($urandom_range(0, 40)),
                     base + chan_type'($urandom_range(0, 40)),
                     base + chan_type'($urandom_range(0, 40)), 1'b0, none);
      end
   endtask

   // Result side: random stalls, then compare each word with the oldest expectation.
   initial begin
      int      stall;
      hsi_type got, want;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : int'($urandom_range(0, 4));
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got = '{rsp_bus.color_class, rsp_bus.hue_degrees, rsp_bus.saturation_pct,
                 rsp_bus.intensity, rsp_bus.balanced_red, rsp_bus.balanced_green,
                 rsp_bus.balanced_blue};
         if (pending_hsi.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %p", got);
         end else begin
            want = pending_hsi.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Directed rows; typed-in results only where they are plain.
   stim_row_type directed[] = '{
      '{16'd0, 16'd0, 16'd0, 1'b1,
        '{rgbcc_pkg::CLASS_BLACK, 9'sd0, 7'd0, 16'd1, 16'd1, 16'd1, 16'd1}},
      '{16'd12, 16'd15, 16'd20, 1'b1,
        '{rgbcc_pkg::CLASS_WHITE, 9'sd0, 7'd0, 16'd60, 16'd60, 16'd60, 16'd60}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{16'd1000, 16'd0, 16'd0, 1'b0, '0},
      '{16'd0, 16'd1000, 16'd0, 1'b0, '0},
      '{16'd0, 16'd0, 16'd1000, 1'b0, '0},
      '{16'd1000, 16'd1250, 16'd0, 1'b0, '0},
      '{16'd0, 16'd1250, 16'd1666, 1'b0, '0},
      '{16'd1000, 16'd0, 16'd1666, 1'b0, '0},
      '{16'd13108, 16'd16384, 16'd21846, 1'b0, '0},
      '{16'hFFFF, 16'd0, 16'd0, 1'b0, '0},
      '{16'd0, 16'hFFFF, 16'h8000, 1'b0, '0},
      '{16'd0, 16'd1, 16'd2, 1'b0, '0},
      '{16'd2, 16'd1, 16'd0, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 16'h7FFF, 1'b0, '0},
      '{16'd100, 16'd100, 16'd99, 1'b0, '0}
   };

   initial begin
      reset <= 1'b1;
      calm = 1'b0;
      cfg_variant = 1'b0;
      cfg_off_red = '0;
      cfg_off_grn = '0;
      cfg_off_blu = '0;
      req_bus.valid <= 1'b0;
      req_bus.raw_red <= '0;
      req_bus.raw_green <= '0;
      req_bus.raw_blue <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.addr <= '0;
      csr_bus.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset configuration.
      foreach (directed[i])
         send_sample(directed[i].r, directed[i].g, directed[i].b, directed[i].known,
                     directed[i].want);
      wait_idle();

      // Phases through several settings, the extremes among them.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: csr_write(rgbcc_pkg::REG_VARIANT, 16'd1);
            1: begin
               csr_write(rgbcc_pkg::REG_VARIANT, 16'd0);
               csr_write(rgbcc_pkg::REG_OFF_RED, 16'hFFFF);
               csr_write(rgbcc_pkg::REG_OFF_GRN, 16'hFFFF);
               csr_write(rgbcc_pkg::REG_OFF_BLU, 16'hFFFF);
            end
            2, 3: begin
               csr_write(rgbcc_pkg::REG_VARIANT, csr_data_type'(phase == 2));
               csr_write(rgbcc_pkg::REG_OFF_RED, csr_data_type'($urandom_range(0, 2000)));
               csr_write(rgbcc_pkg::REG_OFF_GRN, csr_data_type'($urandom_range(0, 2000)));
               csr_write(rgbcc_pkg::REG_OFF_BLU, csr_data_type'($urandom_range(0, 2000)));
            end
            4: begin
               csr_write(rgbcc_pkg::REG_VARIANT, 16'd1);
               csr_write(rgbcc_pkg::REG_OFF_RED, csr_data_type'($urandom));
               csr_write(rgbcc_pkg::REG_OFF_GRN, csr_data_type'($urandom));
               csr_write(rgbcc_pkg::REG_OFF_BLU, csr_data_type'($urandom));
            end
            5: begin
               // Upper data bits of the variant are dropped; unused index is ignored.
               csr_write(rgbcc_pkg::REG_VARIANT, 16'hFFFE);
               csr_write(rgbcc_pkg::REG_OFF_RED, 16'd0);
               csr_write(rgbcc_pkg::REG_OFF_GRN, 16'd0);
               csr_write(rgbcc_pkg::REG_OFF_BLU, 16'd0);
               csr_write(REG_UNUSED, csr_data_type'($urandom));
            end
            default: begin
               csr_write(rgbcc_pkg::REG_VARIANT, 16'd1);
               csr_write(REG_UNUSED, 16'hFFFF);
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Some stretches run with no idling on either side.
            if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            send_random();
         end
         calm = 1'b0;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_hsi.size() == 0)
         $display("** rgb_color_classifier: PASSED **");
      else
         $display("** rgb_color_classifier: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
